// File: rtl/tmdl_pkg.sv
// shared types and constants for the trackball mux direction latch
// no dependencies
`default_nettype none

package tmdl_pkg;

  localparam int NUM_PLAYERS = 4;
  localparam int PLAYER_W    = $clog2(NUM_PLAYERS);
  localparam int POS_W       = 8;
  localparam int BYTE_W      = 8;
  localparam int S_TDATA_W   = 80;
  localparam int S_TUSER_W   = 2;
  localparam int CTRL_LO_BIT = 5;

  typedef enum logic [1:0] {
    FUNC_WRITE  = 2'd0,
    FUNC_READ_A = 2'd1,
    FUNC_READ_B = 2'd2
  } func_t;

  typedef logic [PLAYER_W-1:0] player_t;

  typedef struct packed {
    logic [1:0]                        func;
    logic [BYTE_W-1:0]                 write_data;
    logic [BYTE_W-1:0]                 switches;
    logic [NUM_PLAYERS-1:0][POS_W-1:0] pos_x;
    logic [NUM_PLAYERS-1:0][POS_W-1:0] pos_y;
  } item_t;

endpackage

`default_nettype wire

// File: rtl/tmdl_in_reg.sv
// input register stage: holds one accepted transfer and unpacks it
// depends on tmdl_pkg
`default_nettype none

module tmdl_in_reg
  import tmdl_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [S_TDATA_W-1:0] s_tdata,
  input  wire logic [S_TUSER_W-1:0] s_tuser,
  input  wire logic                 take,
  output logic                      item_valid,
  output item_t                     item
);

  logic [S_TDATA_W-1:0] data_q;
  logic [S_TUSER_W-1:0] user_q;

  assign s_tready = !item_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tready) begin
      item_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      data_q <= s_tdata;
      user_q <= s_tuser;
    end
  end

  always_comb begin
    item.func       = user_q;
    item.write_data = data_q[7:0];
    item.switches   = data_q[15:8];
    for (int p = 0; p < NUM_PLAYERS; p++) begin
      item.pos_x[p] = data_q[16 + 16*p +: POS_W];
      item.pos_y[p] = data_q[24 + 16*p +: POS_W];
    end
  end

endmodule

`default_nettype wire

// File: rtl/tmdl_core.sv
// port decode, stored positions and direction sign latches
// depends on tmdl_pkg
`default_nettype none

module tmdl_core
  import tmdl_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              step,
  input  wire item_t             item,
  input  wire logic              four_player,
  output logic [BYTE_W-1:0]      read_data
);

  logic [1:0]                        control_bits;
  logic [NUM_PLAYERS-1:0][POS_W-1:0] last_x;
  logic [NUM_PLAYERS-1:0][POS_W-1:0] last_y;
  logic [NUM_PLAYERS-1:0]            sign_x;
  logic [NUM_PLAYERS-1:0]            sign_y;

  logic              b5;
  logic              b6;
  logic              do_sample;
  player_t           player;
  logic [BYTE_W-1:0] direct_data;
  logic [POS_W-1:0]  nx;
  logic [POS_W-1:0]  ny;
  logic [POS_W-1:0]  dx;
  logic [POS_W-1:0]  dy;
  logic              x_changed;
  logic              y_changed;
  logic [POS_W-1:0]  x_next;
  logic [POS_W-1:0]  y_next;

  assign b5 = control_bits[0];
  assign b6 = control_bits[1];

  // decode what this transfer does
  always_comb begin
    do_sample   = 1'b0;
    player      = '0;
    direct_data = '0;
    case (item.func)
      FUNC_READ_A: begin
        if (!four_player) begin
          if (b5) begin
            do_sample = 1'b1;
            player    = player_t'(0);
          end else begin
            direct_data = item.switches |
                          {4'b0, sign_x[0], sign_y[0], sign_x[1], sign_y[1]};
          end
        end else begin
          if (!b5 && !b6) begin
            direct_data = {sign_y[0], sign_x[0], sign_y[2], sign_x[2],
                           sign_y[1], sign_x[1], sign_y[3], sign_x[3]};
          end else if (b6) begin
            do_sample = 1'b1;
            player    = b5 ? player_t'(0) : player_t'(1);
          end
        end
      end
      FUNC_READ_B: begin
        if (!four_player) begin
          if (b5) begin
            do_sample = 1'b1;
            player    = player_t'(1);
          end else begin
            direct_data = item.switches;
          end
        end else begin
          if (b6) begin
            do_sample = 1'b1;
            player    = b5 ? player_t'(2) : player_t'(3);
          end else begin
            direct_data = item.switches;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign nx        = item.pos_x[player];
  assign ny        = item.pos_y[player];
  assign dx        = nx - last_x[player];
  assign dy        = ny - last_y[player];
  assign x_changed = nx != last_x[player];
  assign y_changed = ny != last_y[player];
  assign x_next    = x_changed ? nx : last_x[player];
  assign y_next    = y_changed ? ny : last_y[player];

  assign read_data = do_sample ? {y_next[3:0], x_next[3:0]} : direct_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      control_bits <= '0;
      last_x       <= '0;
      last_y       <= '0;
      sign_x       <= '0;
      sign_y       <= '0;
    end else if (step) begin
      if (item.func == FUNC_WRITE) begin
        control_bits <= item.write_data[CTRL_LO_BIT +: 2];
      end
      if (do_sample) begin
        if (x_changed) begin
          last_x[player] <= nx;
          sign_x[player] <= dx[POS_W-1];
        end
        if (y_changed) begin
          last_y[player] <= ny;
          sign_y[player] <= dy[POS_W-1];
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/trackball_mux_direction_latch.sv
// Trackball multiplexer with direction latch. One transfer a cycle while
// m_tready holds: an accepted item is held in the input register, decoded
// there and applied to the stored counts and sign latches as it leaves,
// at the same edge at which its byte lands in the output register, so
// items stream back to back. While the output register waits on m_tready
// the input register keeps its item and s_tready drops.
// s_tuser carries the access
// kind (0 control write, 1 read port A, 2 read port B); writes and unused
// kinds return zero. cfg_we/cfg_wdata set four-player decoding and should
// only change while no transfer is in flight.
// depends on tmdl_pkg, tmdl_in_reg, tmdl_core
`default_nettype none

module trackball_mux_direction_latch
  import tmdl_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic                 cfg_wdata,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  // write_data, switches, pos_x_p1, pos_y_p1, pos_x_p2, pos_y_p2,
  // pos_x_p3, pos_y_p3, pos_x_p4, pos_y_p4
  input  wire logic [S_TDATA_W-1:0] s_tdata,
  // func
  input  wire logic [S_TUSER_W-1:0] s_tuser,
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  // read_data
  output logic [BYTE_W-1:0]         m_tdata
);

  logic              four_player;
  logic              item_valid;
  item_t             item;
  logic              take;
  logic [BYTE_W-1:0] read_data;

  assign take = item_valid && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      four_player <= 1'b0;
    end else if (cfg_we) begin
      four_player <= cfg_wdata;
    end
  end

  tmdl_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  tmdl_core u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (take),
    .item        (item),
    .four_player (four_player),
    .read_data   (read_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (take) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      m_tdata <= read_data;
    end
  end

endmodule

`default_nettype wire
